/* design/qsve_pkg.sv */
// ----------------------------------------------------------------------------
// qsve_pkg
// Shared types, codes and constants of the qubit state vector engine.
// ----------------------------------------------------------------------------
package qsve_pkg;

  localparam int MAX_QUBITS_DEF = 4;
  localparam int AMP_WIDTH_DEF  = 16;

  localparam logic [31:0] INV_SQRT2_Q31 = 32'd1518500250;
  localparam logic [2:0]  AQ_RESET      = 3'd4;
  localparam int          DIV_STEPS     = 63;
  localparam int          SQRT_STEPS    = 32;

  typedef enum logic [2:0] {
    FUNC_INIT = 3'd0,
    FUNC_GATE = 3'd1,
    FUNC_CNOT = 3'd2,
    FUNC_MEAS = 3'd3,
    FUNC_READ = 3'd4
  } func_t;

  typedef enum logic [2:0] {
    GATE_X = 3'd0,
    GATE_Y = 3'd1,
    GATE_Z = 3'd2,
    GATE_H = 3'd3
  } gate_t;

  typedef enum logic [4:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_DISPATCH,
    ST_INIT,
    ST_P_RA,
    ST_P_RB,
    ST_P_LB,
    ST_P_W0,
    ST_P_W1,
    ST_M1_RD,
    ST_M1_AC,
    ST_M_DEC,
    ST_M2_RD,
    ST_M2_AC,
    ST_M_NZ,
    ST_M_DIV,
    ST_M_SQI,
    ST_M_SQRT,
    ST_M3_RD,
    ST_M3_WR,
    ST_R_RD,
    ST_R_CAP,
    ST_DONE
  } state_t;

  typedef enum logic [2:0] {
    WR_NONE,
    WR_RST,
    WR_BASIS,
    WR_PAIR0,
    WR_PAIR1,
    WR_ZERO,
    WR_SCALE
  } wr_kind_t;

  typedef enum logic [1:0] {
    ADDR_I,
    ADDR_J,
    ADDR_B
  } addr_sel_t;

  typedef enum logic [1:0] {
    LIM_DEPTH,
    LIM_DIM,
    LIM_DIV,
    LIM_SQRT
  } lim_t;

  typedef struct packed {
    logic      load;
    logic      cnt_clr;
    logic      cnt_inc;
    lim_t      lim;
    logic      rd_en;
    addr_sel_t rd_sel;
    logic      lat_a0;
    logic      lat_a1;
    wr_kind_t  wr;
    logic      acc_clr;
    logic      acc_pz;
    logic      acc_nrm;
    logic      decide;
    logic      div_init;
    logic      div_step;
    logic      sqrt_init;
    logic      sqrt_step;
    logic      rsp_cap;
    logic      rsp_load;
  } dp_cmd_t;

  typedef struct packed {
    logic [2:0] func;
    logic       bad;
    logic       skip;
    logic       last;
    logic       mismatch;
    logic       norm_zero;
    logic       rsp_free;
  } dp_status_t;

endpackage

/* design/qsve_req_if.sv */
// ----------------------------------------------------------------------------
// qsve_req_if
// Request channel: one operation item with valid/ready.
// ----------------------------------------------------------------------------
interface qsve_req_if;
  logic        valid;
  logic        ready;
  logic [2:0]  func;
  logic [2:0]  gate_kind;
  logic [1:0]  qubit;
  logic [1:0]  control;
  logic [3:0]  basis_index;
  logic [31:0] random_draw;

  modport source (
    output valid, func, gate_kind, qubit, control, basis_index, random_draw,
    input  ready
  );
  modport sink (
    input  valid, func, gate_kind, qubit, control, basis_index, random_draw,
    output ready
  );
endinterface

/* design/qsve_rsp_if.sv */
// ----------------------------------------------------------------------------
// qsve_rsp_if
// Response channel: one result item with valid/ready.
// ----------------------------------------------------------------------------
interface qsve_rsp_if;
  logic               valid;
  logic               ready;
  logic               status;
  logic               measured_bit;
  logic signed [15:0] amp_real;
  logic signed [15:0] amp_imag;

  modport source (
    output valid, status, measured_bit, amp_real, amp_imag,
    input  ready
  );
  modport sink (
    input  valid, status, measured_bit, amp_real, amp_imag,
    output ready
  );
endinterface

/* design/qsve_cfg_if.sv */
// ----------------------------------------------------------------------------
// qsve_cfg_if
// Configuration write channel for the active qubit count.
// ----------------------------------------------------------------------------
interface qsve_cfg_if;
  logic       valid;
  logic       ready;
  logic [2:0] data;

  modport source (output valid, data, input ready);
  modport sink   (input valid, data, output ready);
endinterface

/* design/qubit_state_vector_engine_top.sv */
// ----------------------------------------------------------------------------
// qubit_state_vector_engine_top
// Init sweeps all 2^MAX_QUBITS entries of the amplitude memory; gate, cnot
// and measure sweep the D = 2^n active ones, and a measurement adds 63 divider
// steps and 32 square-root steps. The memory has one read and one write port.
// One item at a time; a new item is taken once the result is registered.
// Reset: a clearing pass over all 2^MAX_QUBITS entries loads basis state zero;
// no item is accepted until it ends.
// ----------------------------------------------------------------------------
module qubit_state_vector_engine_top import qsve_pkg::*; #(
  parameter int MAX_QUBITS = MAX_QUBITS_DEF,
  parameter int AMP_WIDTH  = AMP_WIDTH_DEF
) (
  input logic       clk,
  input logic       rst,
  qsve_req_if.sink  req,
  qsve_rsp_if.source rsp,
  qsve_cfg_if.sink  cfg
);

  // Controller and datapath talk only through these two groups.
  dp_cmd_t    cmd;
  dp_status_t st;

  // Sequencer: one state per step of each amplitude pass.
  qsve_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req.valid),
    .req_ready (req.ready),
    .st        (st),
    .cmd       (cmd)
  );

  // Memory, arithmetic and the result register that frees the input side.
  qsve_dp #(
    .MAX_QUBITS (MAX_QUBITS),
    .AMP_WIDTH  (AMP_WIDTH)
  ) u_dp (
    .clk          (clk),
    .rst          (rst),
    .cfg_valid    (cfg.valid),
    .cfg_ready    (cfg.ready),
    .cfg_data     (cfg.data),
    .func         (req.func),
    .gate_kind    (req.gate_kind),
    .qubit        (req.qubit),
    .control      (req.control),
    .basis_index  (req.basis_index),
    .random_draw  (req.random_draw),
    .rsp_valid    (rsp.valid),
    .rsp_ready    (rsp.ready),
    .status       (rsp.status),
    .measured_bit (rsp.measured_bit),
    .amp_real     (rsp.amp_real),
    .amp_imag     (rsp.amp_imag),
    .cmd          (cmd),
    .st           (st)
  );

  // Drop ready right after an item is taken: one item in flight.
  a_one_in_flight: assert property (@(posedge clk) disable iff (rst)
    (req.valid && req.ready) |=> !req.ready)
    else $error("request accepted while an item is in flight");

  // A measured one only comes with a good status.
  a_mbit_ok: assert property (@(posedge clk) disable iff (rst)
    (rsp.valid && rsp.measured_bit) |-> !rsp.status)
    else $error("measured bit set on a failed item");

  // Failed items carry zero amplitude.
  a_bad_zero: assert property (@(posedge clk) disable iff (rst)
    (rsp.valid && rsp.status) |-> (rsp.amp_real == 16'sd0 && rsp.amp_imag == 16'sd0))
    else $error("amplitude driven on a failed item");

  // Hold off requests during the clearing pass.
  a_clear_busy: assert property (@(posedge clk)
    $past(rst) |-> !req.ready)
    else $error("request ready during reset clearing");

endmodule

/* design/qsve_ctrl.sv */
// ----------------------------------------------------------------------------
// qsve_ctrl
// Sequencer for the engine: walks the amplitude passes of each item.
// ----------------------------------------------------------------------------
module qsve_ctrl import qsve_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       req_valid,
  output logic       req_ready,
  input  dp_status_t st,
  output dp_cmd_t    cmd
);

  state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_CLEAR;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      ST_CLEAR:    if (st.last) state_next = ST_IDLE;
      ST_IDLE:     if (req_valid) state_next = ST_DISPATCH;
      ST_DISPATCH: begin
        if (st.bad) begin
          state_next = ST_DONE;
        end else begin
          case (st.func)
            FUNC_INIT: state_next = ST_INIT;
            FUNC_GATE: state_next = ST_P_RA;
            FUNC_CNOT: state_next = ST_P_RA;
            FUNC_MEAS: state_next = ST_M1_RD;
            FUNC_READ: state_next = ST_R_RD;
            default:   state_next = ST_DONE;
          endcase
        end
      end
      ST_INIT:     if (st.last) state_next = ST_DONE;
      ST_P_RA: begin
        if (!st.skip) state_next = ST_P_RB;
        else if (st.last) state_next = ST_DONE;
      end
      ST_P_RB:     state_next = ST_P_LB;
      ST_P_LB:     state_next = ST_P_W0;
      ST_P_W0:     state_next = ST_P_W1;
      ST_P_W1:     state_next = ST_P_RA;
      ST_M1_RD:    state_next = ST_M1_AC;
      ST_M1_AC:    state_next = st.last ? ST_M_DEC : ST_M1_RD;
      ST_M_DEC:    state_next = ST_M2_RD;
      ST_M2_RD:    state_next = ST_M2_AC;
      ST_M2_AC:    state_next = st.last ? ST_M_NZ : ST_M2_RD;
      ST_M_NZ:     state_next = st.norm_zero ? ST_DONE : ST_M_DIV;
      ST_M_DIV:    if (st.last) state_next = ST_M_SQI;
      ST_M_SQI:    state_next = ST_M_SQRT;
      ST_M_SQRT:   if (st.last) state_next = ST_M3_RD;
      ST_M3_RD:    state_next = ST_M3_WR;
      ST_M3_WR:    state_next = st.last ? ST_DONE : ST_M3_RD;
      ST_R_RD:     state_next = ST_R_CAP;
      ST_R_CAP:    state_next = ST_DONE;
      ST_DONE:     if (st.rsp_free) state_next = ST_IDLE;
      default:     state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd       = '0;
    cmd.lim   = LIM_DIM;
    cmd.rd_sel = ADDR_I;
    cmd.wr    = WR_NONE;
    req_ready = 1'b0;
    case (state)
      ST_CLEAR: begin
        cmd.wr      = WR_RST;
        cmd.lim     = LIM_DEPTH;
        cmd.cnt_inc = 1'b1;
      end
      ST_IDLE: begin
        req_ready = 1'b1;
        cmd.load  = req_valid;
      end
      ST_DISPATCH: begin
        cmd.cnt_clr = 1'b1;
        cmd.acc_clr = 1'b1;
      end
      ST_INIT: begin
        cmd.wr      = WR_BASIS;
        cmd.lim     = LIM_DEPTH;
        cmd.cnt_inc = 1'b1;
      end
      ST_P_RA: begin
        if (st.skip) begin
          cmd.cnt_inc = 1'b1;
        end else begin
          cmd.rd_en = 1'b1;
        end
      end
      ST_P_RB: begin
        cmd.lat_a0 = 1'b1;
        cmd.rd_en  = 1'b1;
        cmd.rd_sel = ADDR_J;
      end
      ST_P_LB:  cmd.lat_a1 = 1'b1;
      ST_P_W0:  cmd.wr = WR_PAIR0;
      ST_P_W1: begin
        cmd.wr      = WR_PAIR1;
        cmd.cnt_inc = 1'b1;
      end
      ST_M1_RD: cmd.rd_en = 1'b1;
      ST_M1_AC: begin
        cmd.acc_pz  = 1'b1;
        cmd.cnt_inc = 1'b1;
      end
      ST_M_DEC: begin
        cmd.decide  = 1'b1;
        cmd.cnt_clr = 1'b1;
        cmd.acc_clr = 1'b1;
      end
      ST_M2_RD: cmd.rd_en = 1'b1;
      ST_M2_AC: begin
        cmd.wr      = st.mismatch ? WR_ZERO : WR_NONE;
        cmd.acc_nrm = 1'b1;
        cmd.cnt_inc = 1'b1;
      end
      ST_M_NZ: begin
        cmd.cnt_clr  = 1'b1;
        cmd.div_init = 1'b1;
      end
      ST_M_DIV: begin
        cmd.lim      = LIM_DIV;
        cmd.div_step = 1'b1;
        cmd.cnt_inc  = 1'b1;
      end
      ST_M_SQI: begin
        cmd.sqrt_init = 1'b1;
        cmd.cnt_clr   = 1'b1;
      end
      ST_M_SQRT: begin
        cmd.lim       = LIM_SQRT;
        cmd.sqrt_step = 1'b1;
        cmd.cnt_inc   = 1'b1;
        cmd.cnt_clr   = st.last;
      end
      ST_M3_RD: cmd.rd_en = 1'b1;
      ST_M3_WR: begin
        cmd.wr      = WR_SCALE;
        cmd.cnt_inc = 1'b1;
      end
      ST_R_RD: begin
        cmd.rd_en  = 1'b1;
        cmd.rd_sel = ADDR_B;
      end
      ST_R_CAP: cmd.rsp_cap = 1'b1;
      ST_DONE:  cmd.rsp_load = st.rsp_free;
      default: begin
        cmd = '0;
      end
    endcase
  end

endmodule

/* design/qsve_dp.sv */
// ----------------------------------------------------------------------------
// qsve_dp
// Datapath: amplitude memory, gate arithmetic, accumulators, divider,
// square root and the response register.
// ----------------------------------------------------------------------------
module qsve_dp import qsve_pkg::*; #(
  parameter int MAX_QUBITS = MAX_QUBITS_DEF,
  parameter int AMP_WIDTH  = AMP_WIDTH_DEF
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                cfg_valid,
  output logic                cfg_ready,
  input  logic [2:0]          cfg_data,
  input  logic [2:0]          func,
  input  logic [2:0]          gate_kind,
  input  logic [1:0]          qubit,
  input  logic [1:0]          control,
  input  logic [3:0]          basis_index,
  input  logic [31:0]         random_draw,
  output logic                rsp_valid,
  input  logic                rsp_ready,
  output logic                status,
  output logic                measured_bit,
  output logic signed [15:0]  amp_real,
  output logic signed [15:0]  amp_imag,
  input  dp_cmd_t             cmd,
  output dp_status_t          st
);

  localparam int AW    = MAX_QUBITS;
  localparam int DEPTH = 1 << AW;
  localparam int IW    = (AW + 1 > 4) ? AW + 1 : 4;
  localparam int CW    = (AW + 1 > 7) ? AW + 1 : 7;
  localparam int FRAC  = AMP_WIDTH - 2;
  localparam int ACCW  = 32 + MAX_QUBITS;
  localparam int PW    = AMP_WIDTH + 33;
  localparam int SW    = 2 * AMP_WIDTH + 8;
  localparam int SQ_R  = (2 * FRAC >= 28) ? 2 * FRAC - 28 : 0;
  localparam int SQ_L  = (2 * FRAC >= 28) ? 0 : 28 - 2 * FRAC;
  localparam int QW    = AMP_WIDTH + 5;
  localparam int QSH_R = (AMP_WIDTH > 16) ? AMP_WIDTH - 16 : 0;
  localparam int QSH_L = (AMP_WIDTH < 16) ? 16 - AMP_WIDTH : 0;
  localparam int QRND  = (1 << QSH_R) >> 1;

  localparam logic signed [AMP_WIDTH-1:0] AMP_MAX = {1'b0, {(AMP_WIDTH-1){1'b1}}};
  localparam logic signed [AMP_WIDTH-1:0] AMP_MIN = {1'b1, {(AMP_WIDTH-1){1'b0}}};
  localparam logic signed [AMP_WIDTH-1:0] AMP_ONE = AMP_WIDTH'(1) << FRAC;

  // -- arithmetic helpers ----------------------------------------------------

  function automatic logic signed [AMP_WIDTH-1:0] neg_sat(
    input logic signed [AMP_WIDTH-1:0] x);
    if (x == AMP_MIN) return AMP_MAX;
    return -x;
  endfunction

  function automatic logic signed [AMP_WIDTH-1:0] sat_mag(
    input logic neg, input logic [PW-1:0] p);
    logic [PW-1:0] lim;
    lim = PW'(1) << (AMP_WIDTH - 1);
    if (p >= lim) return neg ? AMP_MIN : AMP_MAX;
    if (neg) return -(AMP_WIDTH'(p));
    return AMP_WIDTH'(p);
  endfunction

  // Hadamard scaling: round(v / sqrt 2), ties away from zero
  function automatic logic signed [AMP_WIDTH-1:0] h_scale(
    input logic signed [AMP_WIDTH:0] v);
    logic [AMP_WIDTH:0] m;
    logic [PW-1:0]      prod;
    m    = v[AMP_WIDTH] ? (AMP_WIDTH+1)'(-v) : (AMP_WIDTH+1)'(v);
    prod = PW'(m) * PW'(INV_SQRT2_Q31) + (PW'(1) << 30);
    return sat_mag(v[AMP_WIDTH], prod >> 31);
  endfunction

  // Renormalization: round(x * k / 2^17), ties away from zero
  function automatic logic signed [AMP_WIDTH-1:0] m_scale(
    input logic signed [AMP_WIDTH-1:0] x, input logic [31:0] k);
    logic [AMP_WIDTH-1:0] m;
    logic [PW-1:0]        prod;
    m    = x[AMP_WIDTH-1] ? AMP_WIDTH'(-x) : AMP_WIDTH'(x);
    prod = PW'(m) * PW'(k) + (PW'(1) << 16);
    return sat_mag(x[AMP_WIDTH-1], prod >> 17);
  endfunction

  // Squared magnitude with 28 fraction bits
  function automatic logic [30:0] sq28(input logic signed [AMP_WIDTH-1:0] x);
    logic [AMP_WIDTH-1:0] m;
    logic [SW-1:0]        s;
    m = x[AMP_WIDTH-1] ? AMP_WIDTH'(-x) : AMP_WIDTH'(x);
    s = SW'(m) * SW'(m);
    return 31'((s >> SQ_R) << SQ_L);
  endfunction

  function automatic logic signed [15:0] to_q14(input logic signed [AMP_WIDTH-1:0] x);
    logic [AMP_WIDTH-1:0] m;
    logic [QW-1:0]        p;
    m = x[AMP_WIDTH-1] ? AMP_WIDTH'(-x) : AMP_WIDTH'(x);
    p = ((QW'(m) + QW'(QRND)) >> QSH_R) << QSH_L;
    if (!x[AMP_WIDTH-1]) begin
      if (p > QW'(32767)) return 16'sh7fff;
      return 16'(p);
    end
    if (p > QW'(32768)) return 16'sh8000;
    return 16'(QW'(0) - p);
  endfunction

  // -- request and configuration registers -----------------------------------

  logic [2:0]  aq;
  logic [3:0]  nq;
  logic [IW-1:0] dim;
  logic        bad_in;
  logic [2:0]  r_func;
  logic [2:0]  r_kind;
  logic [1:0]  r_q;
  logic [1:0]  r_c;
  logic [3:0]  r_bidx;
  logic [31:0] r_draw;
  logic        r_bad;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      aq <= AQ_RESET;
    end else if (cfg_valid) begin
      aq <= cfg_data;
    end
  end

  always_comb begin
    if (aq == 3'd0) nq = 4'd1;
    else if (32'(aq) > MAX_QUBITS) nq = 4'(MAX_QUBITS);
    else nq = {1'b0, aq};
  end

  assign dim = IW'(1) << nq;

  always_comb begin
    case (func)
      FUNC_INIT: bad_in = IW'(basis_index) >= dim;
      FUNC_GATE: bad_in = (gate_kind > GATE_H) || ({2'b00, qubit} >= nq);
      FUNC_CNOT: bad_in = ({2'b00, qubit} >= nq) || ({2'b00, control} >= nq)
                          || (qubit == control);
      FUNC_MEAS: bad_in = {2'b00, qubit} >= nq;
      FUNC_READ: bad_in = IW'(basis_index) >= dim;
      default:   bad_in = 1'b1;
    endcase
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      r_func <= func;
      r_kind <= gate_kind;
      r_q    <= qubit;
      r_c    <= control;
      r_bidx <= basis_index;
      r_draw <= random_draw;
      r_bad  <= bad_in;
    end
  end

  // -- entry counter ---------------------------------------------------------

  logic [CW-1:0] cnt;
  logic [AW-1:0] idx_i, idx_j, qmask, cmask;
  logic          ibit, cbit, last;

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt <= '0;
    end else if (cmd.cnt_clr) begin
      cnt <= '0;
    end else if (cmd.cnt_inc) begin
      cnt <= cnt + 1'b1;
    end
  end

  assign idx_i = cnt[AW-1:0];
  assign qmask = AW'(1) << r_q;
  assign cmask = AW'(1) << r_c;
  assign idx_j = idx_i | qmask;
  assign ibit  = (idx_i & qmask) != '0;
  assign cbit  = (idx_i & cmask) != '0;

  always_comb begin
    case (cmd.lim)
      LIM_DEPTH: last = cnt == CW'(DEPTH - 1);
      LIM_DIM:   last = cnt == CW'(dim - 1'b1);
      LIM_DIV:   last = cnt == CW'(DIV_STEPS - 1);
      LIM_SQRT:  last = cnt == CW'(SQRT_STEPS - 1);
      default:   last = 1'b1;
    endcase
  end

  // -- amplitude memory ------------------------------------------------------

  logic [2*AMP_WIDTH-1:0] mem [DEPTH];
  logic [2*AMP_WIDTH-1:0] rdata, wdata;
  logic [AW-1:0]          rd_addr, wr_addr;
  logic                   wr_en;
  logic signed [AMP_WIDTH-1:0] rd_re, rd_im;

  always_comb begin
    case (cmd.rd_sel)
      ADDR_I:  rd_addr = idx_i;
      ADDR_J:  rd_addr = idx_j;
      ADDR_B:  rd_addr = AW'(r_bidx);
      default: rd_addr = idx_i;
    endcase
  end

  always_ff @(posedge clk) begin
    if (wr_en) mem[wr_addr] <= wdata;
    if (cmd.rd_en) rdata <= mem[rd_addr];
  end

  assign rd_re = rdata[2*AMP_WIDTH-1:AMP_WIDTH];
  assign rd_im = rdata[AMP_WIDTH-1:0];

  // -- pair arithmetic -------------------------------------------------------

  logic signed [AMP_WIDTH-1:0] a0_re, a0_im, a1_re, a1_im;
  logic signed [AMP_WIDTH-1:0] f0_re, f0_im, f1_re, f1_im;
  logic signed [AMP_WIDTH:0]   s_re, s_im, d_re, d_im;

  always_ff @(posedge clk) begin
    if (cmd.lat_a0) begin
      a0_re <= rd_re;
      a0_im <= rd_im;
    end
    if (cmd.lat_a1) begin
      a1_re <= rd_re;
      a1_im <= rd_im;
    end
  end

  assign s_re = (AMP_WIDTH+1)'(a0_re) + (AMP_WIDTH+1)'(a1_re);
  assign s_im = (AMP_WIDTH+1)'(a0_im) + (AMP_WIDTH+1)'(a1_im);
  assign d_re = (AMP_WIDTH+1)'(a0_re) - (AMP_WIDTH+1)'(a1_re);
  assign d_im = (AMP_WIDTH+1)'(a0_im) - (AMP_WIDTH+1)'(a1_im);

  always_comb begin
    f0_re = a0_re;
    f0_im = a0_im;
    f1_re = a1_re;
    f1_im = a1_im;
    if (r_func == FUNC_CNOT) begin
      if (cbit) begin
        f0_re = a1_re;
        f0_im = a1_im;
        f1_re = a0_re;
        f1_im = a0_im;
      end
    end else begin
      case (r_kind)
        GATE_X: begin
          f0_re = a1_re;
          f0_im = a1_im;
          f1_re = a0_re;
          f1_im = a0_im;
        end
        GATE_Y: begin
          f0_re = a1_im;
          f0_im = neg_sat(a1_re);
          f1_re = neg_sat(a0_im);
          f1_im = a0_re;
        end
        GATE_Z: begin
          f1_re = neg_sat(a1_re);
          f1_im = neg_sat(a1_im);
        end
        GATE_H: begin
          f0_re = h_scale(s_re);
          f0_im = h_scale(s_im);
          f1_re = h_scale(d_re);
          f1_im = h_scale(d_im);
        end
        default: begin
          f0_re = a0_re;
        end
      endcase
    end
  end

  // -- measurement: accumulate, decide, divide, square root ------------------

  logic [ACCW-1:0] acc, sq_sum;
  logic            mbit, mismatch;
  logic [29:0]     pz_c;
  logic [63:0]     m_lhs, m_rhs;
  logic [ACCW-1:0] rem;
  logic [ACCW:0]   rem_sh, rem_diff;
  logic [62:0]     quo;
  logic [63:0]     sv, res, sbit, s_try;
  logic [31:0]     kval;

  assign sq_sum   = ACCW'(sq28(rd_re)) + ACCW'(sq28(rd_im));
  assign mismatch = ibit != mbit;

  assign pz_c  = (acc > ACCW'(32'h2000_0000)) ? 30'h2000_0000 : acc[29:0];
  assign m_lhs = {4'h0, r_draw, 28'h0};
  assign m_rhs = {2'b00, pz_c, 32'h0} - 64'(pz_c);

  always_ff @(posedge clk) begin
    if (cmd.acc_clr) begin
      acc <= '0;
    end else if ((cmd.acc_pz && !ibit) || (cmd.acc_nrm && !mismatch)) begin
      acc <= acc + sq_sum;
    end
    if (cmd.decide) mbit <= !(m_lhs < m_rhs);
  end

  // restoring division of 2^62 by the norm, one quotient bit a step
  assign rem_sh   = {rem, cnt == '0};
  assign rem_diff = rem_sh - {1'b0, acc};

  always_ff @(posedge clk) begin
    if (cmd.div_init) begin
      rem <= '0;
      quo <= '0;
    end else if (cmd.div_step) begin
      if (rem_sh >= {1'b0, acc}) begin
        rem <= ACCW'(rem_diff);
        quo <= {quo[61:0], 1'b1};
      end else begin
        rem <= ACCW'(rem_sh);
        quo <= {quo[61:0], 1'b0};
      end
    end
  end

  // digit-by-digit integer square root, one result bit a step
  assign s_try = res + sbit;
  assign kval  = res[31:0];

  always_ff @(posedge clk) begin
    if (cmd.sqrt_init) begin
      sv   <= {1'b0, quo};
      res  <= '0;
      sbit <= 64'h4000_0000_0000_0000;
    end else if (cmd.sqrt_step) begin
      if (sv >= s_try) begin
        sv  <= sv - s_try;
        res <= (res >> 1) + sbit;
      end else begin
        res <= res >> 1;
      end
      sbit <= sbit >> 2;
    end
  end

  // -- write port ------------------------------------------------------------

  always_comb begin
    wr_en   = 1'b1;
    wr_addr = idx_i;
    wdata   = '0;
    case (cmd.wr)
      WR_NONE:  wr_en = 1'b0;
      WR_RST:   if (idx_i == '0) wdata = {AMP_ONE, {AMP_WIDTH{1'b0}}};
      WR_BASIS: if (IW'(idx_i) == IW'(r_bidx)) wdata = {AMP_ONE, {AMP_WIDTH{1'b0}}};
      WR_PAIR0: wdata = {f0_re, f0_im};
      WR_PAIR1: begin
        wr_addr = idx_j;
        wdata   = {f1_re, f1_im};
      end
      WR_ZERO:  wdata = '0;
      WR_SCALE: wdata = {m_scale(rd_re, kval), m_scale(rd_im, kval)};
      default:  wr_en = 1'b0;
    endcase
  end

  // -- response register -----------------------------------------------------

  logic signed [15:0] cap_re, cap_im;

  always_ff @(posedge clk) begin
    if (cmd.rsp_cap) begin
      cap_re <= to_q14(rd_re);
      cap_im <= to_q14(rd_im);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (cmd.rsp_load) begin
      rsp_valid <= 1'b1;
    end else if (rsp_ready) begin
      rsp_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.rsp_load) begin
      status       <= r_bad;
      measured_bit <= (!r_bad && r_func == FUNC_MEAS) ? mbit : 1'b0;
      amp_real     <= (!r_bad && r_func == FUNC_READ) ? cap_re : 16'sd0;
      amp_imag     <= (!r_bad && r_func == FUNC_READ) ? cap_im : 16'sd0;
    end
  end

  assign st.func      = r_func;
  assign st.bad       = r_bad;
  assign st.skip      = ibit;
  assign st.last      = last;
  assign st.mismatch  = mismatch;
  assign st.norm_zero = acc == '0;
  assign st.rsp_free  = !rsp_valid || rsp_ready;

endmodule

/* verif/qsve_outcome_checker.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// qsve_outcome_checker
// Watches the request, response and configuration channels of the qubit
// state vector engine, keeps its own copy of the state vector, predicts the
// result of every accepted item and compares it with the delivered result.
// ----------------------------------------------------------------------------
module qsve_outcome_checker import qsve_pkg::*; (
  input  logic clk,
  input  logic rst,
  qsve_req_if  req,
  qsve_rsp_if  rsp,
  qsve_cfg_if  cfg,
  output int   fail_count,
  output int   open_count
);

  typedef struct packed {
    logic               status;
    logic               measured_bit;
    logic signed [15:0] amp_real;
    logic signed [15:0] amp_imag;
  } outcome_t;

  int       state_re [16];
  int       state_im [16];
  logic [2:0] qubit_cfg;
  outcome_t outcome_q [$];

  function automatic int clamp16(longint v);
    if (v > 32767) return 32767;
    if (v < -32768) return -32768;
    return int'(v);
  endfunction

  function automatic longint unsigned magnitude(longint v);
    return (v < 0) ? longint'(-v) : longint'(v);
  endfunction

  function automatic int scaled(longint v, longint unsigned k, int sh);
    longint unsigned p;
    p = (magnitude(v) * k + (64'd1 << (sh - 1))) >> sh;
    return clamp16((v < 0) ? -longint'(p) : longint'(p));
  endfunction

  // Squared magnitude with 28 fraction bits; at Q2.14 no shift is needed.
  function automatic longint unsigned square28(int x);
    longint unsigned m;
    m = magnitude(x);
    return m * m;
  endfunction

  function automatic longint unsigned int_sqrt(longint unsigned v);
    longint unsigned root, bitv;
    root = 0;
    bitv = 64'd1 << 62;
    while (bitv > v) bitv = bitv >> 2;
    while (bitv != 0) begin
      if (v >= root + bitv) begin
        v = v - (root + bitv);
        root = (root >> 1) + bitv;
      end else begin
        root = root >> 1;
      end
      bitv = bitv >> 2;
    end
    return root;
  endfunction

  task automatic load_basis(int idx);
    for (int i = 0; i < 16; i++) begin
      state_re[i] = 0;
      state_im[i] = 0;
    end
    state_re[idx] = 1 << 14;
  endtask

  task automatic predict_outcome(input logic [2:0] fn, input logic [2:0] kind,
                                 input logic [1:0] q, input logic [1:0] c,
                                 input logic [3:0] bidx, input logic [31:0] draw,
                                 output outcome_t res);
    int n, dim, tb, cb, j, t_re, t_im, a0r, a0i, a1r, a1i;
    longint unsigned pz, nrm, k;
    n = (qubit_cfg == 0) ? 1 : ((qubit_cfg > 4) ? 4 : qubit_cfg);
    dim = 1 << n;
    res = '0;
    case (fn)
      FUNC_INIT: begin
        if (bidx >= dim) res.status = 1'b1;
        else load_basis(bidx);
      end
      FUNC_GATE: begin
        if (kind > GATE_H || q >= n) begin
          res.status = 1'b1;
        end else begin
          tb = 1 << q;
          for (int i = 0; i < dim; i++) begin
            if ((i & tb) == 0) begin
              j = i | tb;
              a0r = state_re[i]; a0i = state_im[i];
              a1r = state_re[j]; a1i = state_im[j];
              case (kind)
                GATE_X: begin
                  state_re[i] = a1r; state_im[i] = a1i;
                  state_re[j] = a0r; state_im[j] = a0i;
                end
                GATE_Y: begin
                  state_re[i] = a1i;            state_im[i] = clamp16(-longint'(a1r));
                  state_re[j] = clamp16(-longint'(a0i)); state_im[j] = a0r;
                end
                GATE_Z: begin
                  state_re[j] = clamp16(-longint'(a1r));
                  state_im[j] = clamp16(-longint'(a1i));
                end
                default: begin
                  state_re[i] = scaled(longint'(a0r) + a1r, INV_SQRT2_Q31, 31);
                  state_im[i] = scaled(longint'(a0i) + a1i, INV_SQRT2_Q31, 31);
                  state_re[j] = scaled(longint'(a0r) - a1r, INV_SQRT2_Q31, 31);
                  state_im[j] = scaled(longint'(a0i) - a1i, INV_SQRT2_Q31, 31);
                end
              endcase
            end
          end
        end
      end
      FUNC_CNOT: begin
        if (q >= n || c >= n || q == c) begin
          res.status = 1'b1;
        end else begin
          tb = 1 << q;
          cb = 1 << c;
          for (int i = 0; i < dim; i++) begin
            if ((i & cb) != 0 && (i & tb) == 0) begin
              t_re = state_re[i]; t_im = state_im[i];
              state_re[i] = state_re[i | tb]; state_im[i] = state_im[i | tb];
              state_re[i | tb] = t_re; state_im[i | tb] = t_im;
            end
          end
        end
      end
      FUNC_MEAS: begin
        if (q >= n) begin
          res.status = 1'b1;
        end else begin
          tb = 1 << q;
          pz = 0;
          nrm = 0;
          for (int i = 0; i < dim; i++)
            if ((i & tb) == 0) pz += square28(state_re[i]) + square28(state_im[i]);
          if (pz > (64'd1 << 29)) pz = 64'd1 << 29;
          res.measured_bit = ((64'(draw) << 28) < pz * 64'hFFFF_FFFF) ? 1'b0 : 1'b1;
          for (int i = 0; i < dim; i++) begin
            if (((i & tb) != 0) != res.measured_bit) begin
              state_re[i] = 0;
              state_im[i] = 0;
            end
            nrm += square28(state_re[i]) + square28(state_im[i]);
          end
          // Skip renormalization when the collapsed state is empty.
          if (nrm > 0) begin
            k = int_sqrt((64'd1 << 62) / nrm);
            for (int i = 0; i < dim; i++) begin
              state_re[i] = scaled(state_re[i], k, 17);
              state_im[i] = scaled(state_im[i], k, 17);
            end
          end
        end
      end
      FUNC_READ: begin
        if (bidx >= dim) begin
          res.status = 1'b1;
        end else begin
          res.amp_real = state_re[bidx][15:0];
          res.amp_imag = state_im[bidx][15:0];
        end
      end
      default: res.status = 1'b1;
    endcase
  endtask

  always @(posedge clk) begin
    outcome_t want, seen;
    if (rst) begin
      qubit_cfg = AQ_RESET;
      load_basis(0);
      outcome_q.delete();
      fail_count = 0;
    end else begin
      if (cfg.valid && cfg.ready) qubit_cfg = cfg.data;
      if (req.valid && req.ready) begin
        predict_outcome(req.func, req.gate_kind, req.qubit, req.control,
                        req.basis_index, req.random_draw, want);
        outcome_q.push_back(want);
      end
      if (rsp.valid && rsp.ready) begin
        seen = {rsp.status, rsp.measured_bit, rsp.amp_real, rsp.amp_imag};
        if (outcome_q.size() == 0) begin
          $error("result with no item outstanding");
          fail_count++;
        end else begin
          want = outcome_q.pop_front();
          if (seen.status !== want.status) begin
            $error("status: expected %0d, got %0d", want.status, seen.status);
            fail_count++;
          end
          if (seen.measured_bit !== want.measured_bit) begin
            $error("measured_bit: expected %0d, got %0d", want.measured_bit,
                   seen.measured_bit);
            fail_count++;
          end
          if (seen.amp_real !== want.amp_real) begin
            $error("amp_real: expected %0d, got %0d", want.amp_real, seen.amp_real);
            fail_count++;
          end
          if (seen.amp_imag !== want.amp_imag) begin
            $error("amp_imag: expected %0d, got %0d", want.amp_imag, seen.amp_imag);
            fail_count++;
          end
        end
      end
    end
    open_count = outcome_q.size();
  end

endmodule

/* verif/qubit_state_vector_engine_top_test.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// qubit_state_vector_engine_top_test
// Drives gates, CNOTs, measurements, basis loads and amplitude reads into the
// engine under several qubit counts, with random idling on both channels,
// and lets the outcome checker compare every result against its prediction.
// ----------------------------------------------------------------------------
module qubit_state_vector_engine_top_test;
  import qsve_pkg::*;

  localparam int CYCLE_LIMIT = 2_000_000;

  logic clk;
  logic rst;
  int   fail_count, open_count;
  int   cycles = 0;
  int   items_sent, meas_sent, settings_run;
  bit   calm;        // no idling on either side while set
  bit   hold_start;  // ask the result side for one long hold-off

  qsve_req_if req ();
  qsve_rsp_if rsp ();
  qsve_cfg_if cfg ();

  qubit_state_vector_engine_top dut (
    .clk(clk), .rst(rst), .req(req), .rsp(rsp), .cfg(cfg)
  );

  qsve_outcome_checker chk (
    .clk(clk), .rst(rst), .req(req), .rsp(rsp), .cfg(cfg),
    .fail_count(fail_count), .open_count(open_count)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // Watchdog: end the run if the engine stops making progress.
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

  // Result side: drop ready about a quarter of the time, except in calm
  // stretches; on request hold it low for a long counted stretch so the
  // engine fills and backs up the request channel.
  initial begin
    bit held;
    held = 1'b0;
    rsp.ready = 1'b0;
    forever begin
      @(posedge clk);
      if (hold_start && !held) begin
        held = 1'b1;
        rsp.ready <= 1'b0;
        repeat (400) @(posedge clk);
      end
      rsp.ready <= calm || ($urandom_range(0, 99) >= 25);
    end
  end

  // Wait until the handshake that is being offered completes. Ready is
  // sampled mid-cycle, where it is stable, and the item counts at the next
  // rising edge.
  task automatic wait_accept(input bit is_cfg);
    bit taken;
    taken = 1'b0;
    while (!taken) begin
      @(negedge clk);
      taken = is_cfg ? cfg.ready : req.ready;
      @(posedge clk);
    end
  endtask

  // Write the qubit count only with nothing outstanding, and let the engine
  // settle back to idle first.
  task automatic write_qubits(input logic [2:0] value);
    req.valid <= 1'b0;
    @(negedge clk);
    wait (open_count == 0);
    repeat (8) @(posedge clk);
    cfg.valid <= 1'b1;
    cfg.data  <= value;
    wait_accept(1'b1);
    cfg.valid <= 1'b0;
    settings_run++;
  endtask

  task automatic send_item(input logic [2:0] fn, input logic [2:0] kind,
                           input logic [1:0] q, input logic [1:0] c,
                           input logic [3:0] bidx, input logic [31:0] draw);
    // Idle before the item now and then; valid stays high otherwise.
    if (!calm && $urandom_range(0, 99) < 25) begin
      req.valid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
    end
    req.valid       <= 1'b1;
    req.func        <= fn;
    req.gate_kind   <= kind;
    req.qubit       <= q;
    req.control     <= c;
    req.basis_index <= bidx;
    req.random_draw <= draw;
    wait_accept(1'b0);
    items_sent++;
    if (fn == FUNC_MEAS) meas_sent++;
  endtask

  function automatic logic [31:0] pick_draw();
    int r;
    r = $urandom_range(0, 19);
    if (r == 0) return 32'd0;
    if (r == 1) return 32'hFFFF_FFFF;
    return $urandom;
  endfunction

  // One phase of random items at a given qubit count. Most items are
  // well formed for that count; some are full measurement sequences and a
  // tenth is unconstrained noise.
  task automatic run_phase(input logic [2:0] setting, input int count);
    int n, dim, r, sent, q, c;
    n = (setting == 0) ? 1 : ((setting > 4) ? 4 : setting);
    dim = 1 << n;
    sent = 0;
    while (sent < count) begin
      r = $urandom_range(0, 99);
      if (r < 10) begin
        send_item(3'($urandom_range(0, 7)), 3'($urandom_range(0, 7)),
                  2'($urandom_range(0, 3)), 2'($urandom_range(0, 3)),
                  4'($urandom_range(0, 15)), $urandom);
        sent++;
      end else if (r < 22) begin
        // Full readout: measure qubits 0 upward, then reload a basis state.
        for (int b = 0; b < n; b++)
          send_item(FUNC_MEAS, GATE_X, 2'(b), 2'd0, 4'd0, pick_draw());
        send_item(FUNC_INIT, GATE_X, 2'd0, 2'd0, 4'($urandom_range(0, dim - 1)), 32'd0);
        sent += n + 1;
      end else begin
        q = $urandom_range(0, n - 1);
        c = $urandom_range(0, n - 1);
        if (n > 1 && c == q) c = (q + 1) % n;
        case ($urandom_range(0, 9))
          0:       send_item(FUNC_INIT, GATE_X, 2'(q), 2'(c),
                             4'($urandom_range(0, dim - 1)), 32'd0);
          1, 2, 3: send_item(FUNC_GATE, 3'($urandom_range(0, 3)), 2'(q), 2'(c),
                             4'd0, 32'd0);
          4:       send_item(FUNC_GATE, GATE_H, 2'(q), 2'(c), 4'd0, 32'd0);
          5:       send_item(FUNC_CNOT, GATE_X, 2'(q), 2'(c), 4'd0, 32'd0);
          6:       send_item(FUNC_MEAS, GATE_X, 2'(q), 2'(c), 4'd0, pick_draw());
          default: send_item(FUNC_READ, GATE_X, 2'(q), 2'(c),
                             4'($urandom_range(0, dim - 1)), 32'd0);
        endcase
        sent++;
      end
    end
  endtask

  initial begin
    rst         = 1'b1;
    calm        = 1'b0;
    hold_start  = 1'b0;
    items_sent  = 0;
    meas_sent   = 0;
    settings_run = 0;
    req.valid = 1'b0; req.func = FUNC_INIT; req.gate_kind = GATE_X;
    req.qubit = '0;   req.control = '0;     req.basis_index = '0;
    req.random_draw = '0;
    cfg.valid = 1'b0; cfg.data = AQ_RESET;
    repeat (7) @(posedge clk);
    rst <= 1'b0;

    // Directed part at the reset qubit count of four.
    send_item(FUNC_READ, GATE_X, 0, 0, 0, 0);
    send_item(FUNC_INIT, GATE_X, 0, 0, 15, 0);
    send_item(FUNC_READ, GATE_X, 0, 0, 15, 0);
    send_item(FUNC_GATE, GATE_X, 3, 0, 0, 0);
    send_item(FUNC_GATE, GATE_Y, 1, 0, 0, 0);
    send_item(FUNC_GATE, GATE_Z, 0, 0, 0, 0);
    send_item(FUNC_GATE, GATE_H, 2, 0, 0, 0);
    send_item(FUNC_CNOT, GATE_X, 1, 2, 0, 0);
    send_item(FUNC_READ, GATE_X, 0, 0, 5, 0);
    send_item(FUNC_CNOT, GATE_X, 3, 3, 0, 0);     // control equals target
    send_item(FUNC_GATE, 3'd7, 0, 0, 0, 0);       // bad gate kind
    send_item(3'd5, GATE_X, 0, 0, 0, 0);          // unknown functions
    send_item(3'd7, 3'd7, 3, 3, 15, 32'hFFFF_FFFF);
    send_item(FUNC_MEAS, GATE_X, 2, 0, 0, 32'd0);
    send_item(FUNC_MEAS, GATE_X, 0, 0, 0, 32'hFFFF_FFFF);
    // Certain zero outcome measured as one: the state collapses to nothing.
    send_item(FUNC_INIT, GATE_X, 0, 0, 0, 0);
    send_item(FUNC_MEAS, GATE_X, 0, 0, 0, 32'hFFFF_FFFF);
    send_item(FUNC_READ, GATE_X, 0, 0, 0, 0);
    send_item(FUNC_GATE, GATE_H, 0, 0, 0, 0);
    send_item(FUNC_INIT, GATE_X, 0, 0, 0, 0);
    send_item(FUNC_GATE, GATE_H, 0, 0, 0, 0);
    send_item(FUNC_GATE, GATE_H, 3, 0, 0, 0);
    send_item(FUNC_MEAS, GATE_X, 3, 0, 0, 32'h8000_0000);
    send_item(FUNC_READ, GATE_X, 0, 0, 8, 0);

    // Random part: a calm stretch first, then normal idling.
    calm = 1'b1;
    run_phase(3'd4, 80);
    calm = 1'b0;
    write_qubits(3'd1);
    run_phase(3'd1, 90);
    // Long hold-off on results while items keep coming.
    write_qubits(3'd4);
    hold_start = 1'b1;
    run_phase(3'd4, 100);
    // Pause the request side until every result has come back.
    req.valid <= 1'b0;
    @(negedge clk);
    wait (open_count == 0);
    run_phase(3'd4, 60);
    write_qubits(3'd2);
    run_phase(3'd2, 90);
    write_qubits(3'd0);
    run_phase(3'd0, 70);
    write_qubits(3'd3);
    run_phase(3'd3, 100);
    write_qubits(3'd7);
    run_phase(3'd7, 80);
    write_qubits(3'd5);
    run_phase(3'd5, 60);
    write_qubits(3'd4);
    run_phase(3'd4, 200);
    req.valid <= 1'b0;

    // Drain, then idle before the final report.
    @(negedge clk);
    wait (open_count == 0);
    repeat (300) @(posedge clk);
    $display("Sent %0d items, %0d of them measurements, over %0d qubit-count writes.",
             items_sent, meas_sent, settings_run);
    if (fail_count == 0 && open_count == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
